[rtl/gop_pkg.sv]
package gop_pkg;

	// Angle accumulator: 32 bits, units of pi / 2^31.
	localparam int ZW = 32;
	localparam logic [ZW-1:0] Z_PI = 32'h8000_0000;

	// atan(2^-i) in units of pi / 2^31.
	localparam int ATAN_LEN = 24;
	localparam logic [ZW-1:0] ATAN_TAB [ATAN_LEN] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
		32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
	};

endpackage

[rtl/gradient_orientation_pixel.sv]
// Gradient magnitude and orientation of one pixel from its four neighbors.
//
// Request channel: drive the four neighbor intensities, their undefined flags
// and on_border together with start. A request is taken at every rising edge
// with start high and busy low; busy stays low, so a new request may come in
// every cycle.
// Result channel: done is high for exactly one cycle per request, with angle,
// angle_defined and magnitude valid in that cycle only. Results leave in
// request order. The receiver cannot stall, and none is needed: every stage
// moves forward each cycle.
// Depth: LAT is the longer of the CORDIC path (2 + CORDIC_STAGES, capped at
// ATAN_LEN) and the square root path (3 + PIXEL_BITS+2, one root bit per
// stage); done is registered from stage LAT. One request per cycle sustained.
// Reset: arst_n clears every valid bit at once; requests in flight are dropped
// and no done appears until new requests have passed through.
// angle_defined is low (angle and magnitude zero) for border pixels, pixels
// with an undefined neighbor, and a zero gradient.
module gradient_orientation_pixel
	import gop_pkg::*;
#(
	parameter int PIXEL_BITS    = 16,
	parameter int ANGLE_BITS    = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [PIXEL_BITS-1:0]        left_pixel,
	input  logic [PIXEL_BITS-1:0]        right_pixel,
	input  logic [PIXEL_BITS-1:0]        above_pixel,
	input  logic [PIXEL_BITS-1:0]        below_pixel,
	input  logic                         left_undefined,
	input  logic                         right_undefined,
	input  logic                         above_undefined,
	input  logic                         below_undefined,
	input  logic                         on_border,
	output logic                         done,
	output logic signed [ANGLE_BITS-1:0] angle,
	output logic                         angle_defined,
	output logic [PIXEL_BITS:0]          magnitude
);

	// Widths
	localparam int DW    = PIXEL_BITS + 1;          // central difference, signed
	localparam int PQW   = 2 * PIXEL_BITS;          // one squared difference
	localparam int SW    = 2 * PIXEL_BITS + 1;      // sum of squares
	localparam int QW    = PIXEL_BITS + 2;          // root of 4*sum, one extra bit
	localparam int RW    = 2 * QW;                  // radicand
	localparam int RMW   = QW + 3;                  // partial remainder
	localparam int CW    = PIXEL_BITS + CORDIC_STAGES + 3;  // CORDIC x/y
	localparam int NIT   = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

	// Stage numbers at which each path finishes
	localparam int LAT_C = 2 + NIT;
	localparam int LAT_M = 3 + QW;
	localparam int LAT   = (LAT_C > LAT_M) ? LAT_C : LAT_M;
	localparam int ZD    = LAT - LAT_C;
	localparam int MD    = LAT - LAT_M;

	localparam logic [ZW-1:0] Z_RND = ZW'(1) << (31 - ANGLE_BITS);

	// Fully pipelined: never refuses a request.
	assign busy = 1'b0;

	// ------------------------------------------------------------------
	// Valid and defined bits, one per stage
	// ------------------------------------------------------------------
	logic [LAT:1] vld_s;
	logic [LAT:1] def_s;

	logic signed [DW-1:0] dx_s1, dy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[LAT-1:1], start & ~busy};
		end
	end

	always_ff @(posedge clk) begin
		def_s[1] <= ~(left_undefined | right_undefined | above_undefined |
			below_undefined | on_border);
		def_s[2] <= def_s[1] & ~((dx_s1 == '0) && (dy_s1 == '0));
		for (int k = 3; k <= LAT; k++) begin
			def_s[k] <= def_s[k-1];
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: central differences
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		dx_s1 <= {1'b0, right_pixel} - {1'b0, left_pixel};
		dy_s1 <= {1'b0, below_pixel} - {1'b0, above_pixel};
	end

	// ------------------------------------------------------------------
	// Magnitude path: squares (s2), sum (s3), then one root bit per stage
	// ------------------------------------------------------------------
	logic signed [2*DW-1:0] sq_x, sq_y;
	logic [PQW-1:0]         dxsq_s2, dysq_s2;
	logic [SW-1:0]          sum_s3;

	assign sq_x = dx_s1 * dx_s1;
	assign sq_y = dy_s1 * dy_s1;

	always_ff @(posedge clk) begin
		dxsq_s2 <= sq_x[PQW-1:0];
		dysq_s2 <= sq_y[PQW-1:0];
		sum_s3  <= {1'b0, dxsq_s2} + {1'b0, dysq_s2};
	end

	// Restoring square root of 4*sum; rounding to nearest falls out of the
	// extra low root bit.
	logic [RW-1:0]  rad_s  [QW];
	logic [RMW-1:0] rem_s  [QW];
	logic [QW-1:0]  root_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_sqrt
		logic [RW-1:0]  rad_in;
		logic [RMW-1:0] rem_in, rem_t, trial;
		logic [QW-1:0]  root_in;

		if (k == 0) begin : g_first
			assign rad_in  = {1'b0, sum_s3, 2'b00};
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign rad_in  = rad_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
		end

		assign rem_t = {rem_in[RMW-3:0], rad_in[RW-1 -: 2]};
		assign trial = RMW'({root_in, 2'b01});

		always_ff @(posedge clk) begin
			rad_s[k] <= rad_in << 2;
			if (rem_t >= trial) begin
				rem_s[k]  <= rem_t - trial;
				root_s[k] <= {root_in[QW-2:0], 1'b1};
			end else begin
				rem_s[k]  <= rem_t;
				root_s[k] <= {root_in[QW-2:0], 1'b0};
			end
		end
	end

	// ------------------------------------------------------------------
	// Angle path: CORDIC in vectoring mode, init at s2, one rotation a stage
	// ------------------------------------------------------------------
	logic signed [CW-1:0] cx_s [NIT+1];
	logic signed [CW-1:0] cy_s [NIT+1];
	logic [ZW-1:0]        cz_s [NIT+1];
	logic signed [CW-1:0] dx_ext, dy_ext;

	assign dx_ext = CW'(dx_s1);
	assign dy_ext = CW'(dy_s1);

	// Left half-plane: flip the vector and start from pi.
	always_ff @(posedge clk) begin
		if (dx_s1[DW-1]) begin
			cx_s[0] <= (-dx_ext) <<< CORDIC_STAGES;
			cy_s[0] <= (-dy_ext) <<< CORDIC_STAGES;
			cz_s[0] <= Z_PI;
		end else begin
			cx_s[0] <= dx_ext <<< CORDIC_STAGES;
			cy_s[0] <= dy_ext <<< CORDIC_STAGES;
			cz_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < NIT; i++) begin : g_cordic
		logic signed [CW-1:0] xs, ys;

		assign xs = cx_s[i] >>> i;
		assign ys = cy_s[i] >>> i;

		always_ff @(posedge clk) begin
			if (!cy_s[i][CW-1]) begin
				cx_s[i+1] <= cx_s[i] + ys;
				cy_s[i+1] <= cy_s[i] - xs;
				cz_s[i+1] <= cz_s[i] + ATAN_TAB[i];
			end else begin
				cx_s[i+1] <= cx_s[i] - ys;
				cy_s[i+1] <= cy_s[i] + xs;
				cz_s[i+1] <= cz_s[i] - ATAN_TAB[i];
			end
		end
	end

	// ------------------------------------------------------------------
	// Balance the two paths to stage LAT
	// ------------------------------------------------------------------
	logic [ZW-1:0] z_al;
	logic [QW-1:0] root_al;

	if (ZD > 0) begin : g_zdly
		logic [ZW-1:0] zdl_s [ZD];
		always_ff @(posedge clk) begin
			zdl_s[0] <= cz_s[NIT];
			for (int k = 1; k < ZD; k++) begin
				zdl_s[k] <= zdl_s[k-1];
			end
		end
		assign z_al = zdl_s[ZD-1];
	end else begin : g_znodly
		assign z_al = cz_s[NIT];
	end

	if (MD > 0) begin : g_mdly
		logic [QW-1:0] mdl_s [MD];
		always_ff @(posedge clk) begin
			mdl_s[0] <= root_s[QW-1];
			for (int k = 1; k < MD; k++) begin
				mdl_s[k] <= mdl_s[k-1];
			end
		end
		assign root_al = mdl_s[MD-1];
	end else begin : g_mnodly
		assign root_al = root_s[QW-1];
	end

	// ------------------------------------------------------------------
	// Output stage: round angle, halve root with rounding, zero when undefined
	// ------------------------------------------------------------------
	logic [ZW-1:0] z_rnd;
	logic [QW:0]   root_inc;

	assign z_rnd    = z_al + Z_RND;
	assign root_inc = {1'b0, root_al} + (QW+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s[LAT];
		end
	end

	always_ff @(posedge clk) begin
		angle_defined <= def_s[LAT];
		if (def_s[LAT]) begin
			angle     <= z_rnd[ZW-1 -: ANGLE_BITS];
			magnitude <= root_inc[PIXEL_BITS+1:1];
		end else begin
			angle     <= '0;
			magnitude <= '0;
		end
	end

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
`ifndef SYNTHESIS
	// Every result traces back to a request that entered the pipeline.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT + 1))
		else $error("result without matching request");

	// Undefined angle carries zero angle and magnitude.
	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !angle_defined) |-> (angle == '0 && magnitude == '0))
		else $error("undefined result not zeroed");

	// A defined angle implies a nonzero gradient.
	a_def_mag: assert property (@(posedge clk) disable iff (!arst_n)
		(done && angle_defined) |-> (magnitude != '0))
		else $error("defined angle with zero magnitude");
`endif

endmodule
